>>> rtl/core/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular double-ended queue
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;

    localparam int unsigned MODE_W   = 2;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    // request layout on s_tdata, lowest bit first
    localparam int unsigned S_MODE_LSB  = 0;
    localparam int unsigned S_VALUE_LSB = S_MODE_LSB + MODE_W;
    localparam int unsigned S_USED_W    = S_VALUE_LSB + VALUE_W;
    localparam int unsigned S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    // result layout on m_tdata, lowest bit first
    localparam int unsigned M_STATUS_LSB = 0;
    localparam int unsigned M_EMPTY_BIT  = M_STATUS_LSB + STATUS_W;
    localparam int unsigned M_FULL_BIT   = M_EMPTY_BIT + 1;
    localparam int unsigned M_COUNT_LSB  = M_FULL_BIT + 1;
    localparam int unsigned M_HEAD_LSB   = M_COUNT_LSB + COUNT_W;
    localparam int unsigned M_TAIL_LSB   = M_HEAD_LSB + VALUE_W;
    localparam int unsigned M_USED_W     = M_TAIL_LSB + VALUE_W;
    localparam int unsigned M_TDATA_W    = ((M_USED_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_REAR  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LOAD = 1'b1
    } state_t;

endpackage

>>> rtl/core/circular_deque_top.sv
// ----------------------------------------------------------------------------
// circular_deque_top
// Indices, storage write and storage read data are all registered at the accepting
// edge; the LOAD state then loads the result into the output register once it is free.
// A new request is taken only in the idle state, after the previous result is loaded.
// The output register lets a new request in while a result waits.
// Reset: synchronous active-low; queue empty, both indices at zero,
// storage contents undefined until written.
// ----------------------------------------------------------------------------
module circular_deque_top #(
    parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // mode[1:0], item_value[33:2], zero padding
    input  logic [cdq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], is_empty[2], is_full[3], element_count[8:4],
    // head_value[40:9], tail_value[72:41], zero padding
    output logic [cdq_pkg::M_TDATA_W-1:0] m_tdata
);
    import cdq_pkg::*;

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    state_t state_reg, state_next;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             empty_reg, empty_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [M_TDATA_W-1:0]   result_word;

    status_t              status_reg, status_next;
    logic                 fwd_head_reg, fwd_tail_reg;
    logic [VALUE_W-1:0]   fwd_val_reg;
    logic [VALUE_W-1:0]   rd_head_reg, rd_tail_reg;

    logic [VALUE_W-1:0]   storage [DEPTH];

    mode_t                req_mode;
    logic [VALUE_W-1:0]   req_value;
    logic                 accept;
    logic                 load_out;
    logic                 full_now;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;

    logic                 full_after;
    logic [CNT_W-1:0]     count_after;
    logic [VALUE_W-1:0]   head_val, tail_val;

    assign req_mode  = mode_t'(s_tdata[S_MODE_LSB +: MODE_W]);
    assign req_value = s_tdata[S_VALUE_LSB +: VALUE_W];
    assign accept    = s_tvalid && s_tready;
    assign full_now  = !empty_reg && (wrap_inc(tail_reg) == head_reg);

    // operation decode on the current indices
    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        status_next = ST_DONE;
        wr_en       = 1'b0;
        wr_addr     = '0;
        case (req_mode)
            MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                if (empty_reg) begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b0;
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                end else if (full_now) begin
                    status_next = ST_FULL;
                end else if (req_mode == MODE_PUSH_FRONT) begin
                    head_next = wrap_dec(head_reg);
                    wr_en     = 1'b1;
                    wr_addr   = head_next;
                end else begin
                    tail_next = wrap_inc(tail_reg);
                    wr_en     = 1'b1;
                    wr_addr   = tail_next;
                end
            end
            MODE_POP_FRONT, MODE_POP_REAR: begin
                if (empty_reg) begin
                    status_next = ST_EMPTY;
                end else if (head_reg == tail_reg) begin
                    empty_next = 1'b1;
                    head_next  = '0;
                    tail_next  = '0;
                end else if (req_mode == MODE_POP_FRONT) begin
                    head_next = wrap_inc(head_reg);
                end else begin
                    tail_next = wrap_dec(tail_reg);
                end
            end
            default: begin
                status_next = ST_DONE;
            end
        endcase
    end

    // storage: write and read at the new indices in the same cycle
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (wr_en) begin
                storage[wr_addr] <= req_value;
            end
            rd_head_reg <= storage[head_next];
            rd_tail_reg <= storage[tail_next];
        end
    end

    // read returns the old word, so forward a write to the same entry
    always_ff @(posedge aclk) begin
        if (accept) begin
            fwd_head_reg <= wr_en && (wr_addr == head_next);
            fwd_tail_reg <= wr_en && (wr_addr == tail_next);
            fwd_val_reg  <= req_value;
            status_reg   <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            empty_reg    <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (accept) begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                empty_reg <= empty_next;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb begin
        s_tready = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
            end
            S_LOAD: begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // result fields from the updated indices
    always_comb begin
        full_after = !empty_reg && (wrap_inc(tail_reg) == head_reg);
        if (empty_reg) begin
            count_after = '0;
        end else if (tail_reg >= head_reg) begin
            count_after = {1'b0, tail_reg} - {1'b0, head_reg} + 1'b1;
        end else begin
            count_after = CNT_W'(DEPTH) - {1'b0, head_reg} + {1'b0, tail_reg} + 1'b1;
        end
        head_val = fwd_head_reg ? fwd_val_reg : rd_head_reg;
        tail_val = fwd_tail_reg ? fwd_val_reg : rd_tail_reg;
        if (empty_reg) begin
            head_val = '0;
            tail_val = '0;
        end
    end

    always_comb begin
        result_word = '0;
        result_word[M_STATUS_LSB +: STATUS_W] = status_reg;
        result_word[M_EMPTY_BIT]              = empty_reg;
        result_word[M_FULL_BIT]               = full_after;
        result_word[M_COUNT_LSB +: COUNT_W]   = COUNT_W'(count_after);
        result_word[M_HEAD_LSB +: VALUE_W]    = head_val;
        result_word[M_TAIL_LSB +: VALUE_W]    = tail_val;
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= result_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/core/cdq_checker.sv
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks on the circular deque, bound to the top level
// ----------------------------------------------------------------------------
module cdq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [cdq_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cdq_pkg::M_TDATA_W-1:0] m_tdata
);
    import cdq_pkg::*;

    logic [STATUS_W-1:0] r_status;
    logic                r_empty;
    logic                r_full;
    logic [COUNT_W-1:0]  r_count;
    logic [VALUE_W-1:0]  r_head;
    logic [VALUE_W-1:0]  r_tail;

    assign r_status = m_tdata[M_STATUS_LSB +: STATUS_W];
    assign r_empty  = m_tdata[M_EMPTY_BIT];
    assign r_full   = m_tdata[M_FULL_BIT];
    assign r_count  = m_tdata[M_COUNT_LSB +: COUNT_W];
    assign r_head   = m_tdata[M_HEAD_LSB +: VALUE_W];
    assign r_tail   = m_tdata[M_TAIL_LSB +: VALUE_W];

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in flight");

    // a rejected push leaves the queue full
    a_full_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && r_status == ST_FULL) |-> (r_full && !r_empty))
        else $error("full rejection without a full queue");

    // a rejected pop leaves the queue empty
    a_empty_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && r_status == ST_EMPTY) |-> (r_empty && !r_full))
        else $error("empty rejection without an empty queue");

    // an empty queue reports zero count and zero values
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && r_empty) |-> (r_count == '0 && r_head == '0 && r_tail == '0))
        else $error("empty queue with non-zero fields");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind circular_deque_top cdq_checker u_cdq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/circular_deque_top_tb.sv
// ----------------------------------------------------------------------------
// circular_deque_top_tb
// Self-checking bench for the circular double-ended queue. A short table of
// directed requests covers empty and full rejections, extreme values and the
// wrap of the front index. A random mix follows that swings between filling and
// draining. Each result is checked against a shadow copy of the queue, or against
// the typed table entry, with random gaps on the request side and back-pressure on the results.
// ----------------------------------------------------------------------------
module circular_deque_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    localparam int unsigned DEPTH     = DEPTH_DEFAULT;
    localparam int unsigned IDX_W     = $clog2(DEPTH);
    localparam int          N_RANDOM  = 700;

    typedef struct packed {
        status_t              status;
        logic                 is_empty;
        logic                 is_full;
        logic [COUNT_W-1:0]   element_count;
        logic [VALUE_W-1:0]   head_value;
        logic [VALUE_W-1:0]   tail_value;
    } deque_result_t;

    typedef struct {
        mode_t                op;
        logic [VALUE_W-1:0]   value;
        bit                   typed;
        deque_result_t        want;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    // shadow copy of the queue
    logic [VALUE_W-1:0] shadow_store [DEPTH];
    logic [IDX_W-1:0]   front_idx;
    logic [IDX_W-1:0]   rear_idx;
    bit                 shadow_empty;

    deque_result_t awaiting_results [$];
    stim_row_t     directed_rows [$];

    int  error_count  = 0;
    int  reqs_sent    = 0;
    int  results_seen = 0;
    int  full_rejects = 0;
    int  empty_rejects = 0;
    int  times_full   = 0;
    bit  no_idle      = 1'b0;

    circular_deque_top #(.DEPTH(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        return (i + 1 >= DEPTH) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
        return (i == 0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    function automatic bit shadow_full();
        return !shadow_empty && idx_next(rear_idx) == front_idx;
    endfunction

    function automatic deque_result_t make_result(input status_t st, input logic emp,
                                                  input logic ful, input int cnt,
                                                  input logic [VALUE_W-1:0] hv,
                                                  input logic [VALUE_W-1:0] tv);
        deque_result_t r;
        r.status        = st;
        r.is_empty      = emp;
        r.is_full       = ful;
        r.element_count = COUNT_W'(cnt);
        r.head_value    = hv;
        r.tail_value    = tv;
        return r;
    endfunction

    function automatic stim_row_t make_row(input mode_t op, input logic [VALUE_W-1:0] v,
                                           input bit typed, input deque_result_t want);
        stim_row_t row;
        row.op    = op;
        row.value = v;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    // applies one operation to the shadow queue and returns the result it gives
    function automatic deque_result_t predict_deque_op(input mode_t op,
                                                       input logic [VALUE_W-1:0] v);
        deque_result_t r;
        int unsigned   cnt;
        r.status = ST_DONE;
        if (op == MODE_PUSH_FRONT || op == MODE_PUSH_REAR) begin
            if (shadow_empty) begin
                // first element always lands in entry 0
                front_idx       = '0;
                rear_idx        = '0;
                shadow_store[0] = v;
                shadow_empty    = 1'b0;
            end else if (shadow_full()) begin
                r.status = ST_FULL;
            end else if (op == MODE_PUSH_FRONT) begin
                front_idx               = idx_prev(front_idx);
                shadow_store[front_idx] = v;
            end else begin
                rear_idx               = idx_next(rear_idx);
                shadow_store[rear_idx] = v;
            end
        end else begin
            if (shadow_empty) begin
                r.status = ST_EMPTY;
            end else if (front_idx == rear_idx) begin
                shadow_empty = 1'b1;
                front_idx    = '0;
                rear_idx     = '0;
            end else if (op == MODE_POP_FRONT) begin
                front_idx = idx_next(front_idx);
            end else begin
                rear_idx = idx_prev(rear_idx);
            end
        end
        if (shadow_empty)
            cnt = 0;
        else if (rear_idx >= front_idx)
            cnt = rear_idx - front_idx + 1;
        else
            cnt = DEPTH - front_idx + rear_idx + 1;
        r.is_empty      = shadow_empty;
        r.is_full       = shadow_full();
        r.element_count = COUNT_W'(cnt);
        r.head_value    = shadow_empty ? '0 : shadow_store[front_idx];
        r.tail_value    = shadow_empty ? '0 : shadow_store[rear_idx];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input mode_t op, input logic [VALUE_W-1:0] v,
                                input bit typed, input deque_result_t want);
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        deque_result_t        predicted;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        word                             = '0;
        word[S_MODE_LSB +: MODE_W]       = op;
        word[S_VALUE_LSB +: VALUE_W]     = v;
        s_tdata  = word;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_deque_op(op, v);
        awaiting_results.push_back(typed ? want : predicted);
        reqs_sent++;
        @(negedge aclk);
    endtask

    // back-pressure on the result side
    initial begin : ready_driver
        int hold;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (no_idle) begin
                m_tready = 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else if (m_tready) begin
                m_tready = 1'b0;
                hold     = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
            end else begin
                m_tready = 1'b1;
                hold     = $urandom_range(0, 20);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        deque_result_t got;
        deque_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status        = status_t'(m_tdata[M_STATUS_LSB +: STATUS_W]);
            got.is_empty      = m_tdata[M_EMPTY_BIT];
            got.is_full       = m_tdata[M_FULL_BIT];
            got.element_count = m_tdata[M_COUNT_LSB +: COUNT_W];
            got.head_value    = m_tdata[M_HEAD_LSB +: VALUE_W];
            got.tail_value    = m_tdata[M_TAIL_LSB +: VALUE_W];
            results_seen++;
            if (awaiting_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("[%0t] unexpected result %h", $realtime, m_tdata);
            end else begin
                want = awaiting_results.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $write("[%0t] result %0d: expected st=%0d e=%0b f=%0b n=%0d h=%h t=%h",
                               $realtime, results_seen,
                               want.status, want.is_empty, want.is_full,
                               want.element_count, want.head_value, want.tail_value);
                        $display(", got st=%0d e=%0b f=%0b n=%0d h=%h t=%h",
                                 got.status, got.is_empty, got.is_full,
                                 got.element_count, got.head_value, got.tail_value);
                    end
                end
                if (want.status == ST_FULL)  full_rejects++;
                if (want.status == ST_EMPTY) empty_rejects++;
                if (want.is_full)            times_full++;
            end
        end
    end

    initial begin : watchdog
        #5ms;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        deque_result_t none;
        deque_result_t empty_res;
        deque_result_t full_res;
        mode_t         op;
        int            bias;
        int            phase_left;
        bit            want_push;

        s_tvalid     = 1'b0;
        s_tdata      = '0;
        aresetn      = 1'b0;
        front_idx    = '0;
        rear_idx     = '0;
        shadow_empty = 1'b1;
        none         = '0;
        empty_res    = make_result(ST_DONE, 1'b1, 1'b0, 0, '0, '0);
        full_res     = make_result(ST_FULL, 1'b0, 1'b1, DEPTH, 32'h10e, 32'h10f);

        // pops straight after reset, extremes, drain to empty
        directed_rows.push_back(make_row(MODE_POP_FRONT, 32'h1234_5678, 1'b1,
            make_result(ST_EMPTY, 1'b1, 1'b0, 0, '0, '0)));
        directed_rows.push_back(make_row(MODE_POP_REAR, 32'hffff_ffff, 1'b1,
            make_result(ST_EMPTY, 1'b1, 1'b0, 0, '0, '0)));
        directed_rows.push_back(make_row(MODE_PUSH_REAR, 32'h8000_0000, 1'b1,
            make_result(ST_DONE, 1'b0, 1'b0, 1, 32'h8000_0000, 32'h8000_0000)));
        directed_rows.push_back(make_row(MODE_PUSH_FRONT, 32'h7fff_ffff, 1'b0, none));
        directed_rows.push_back(make_row(MODE_POP_REAR, 32'h0, 1'b0, none));
        directed_rows.push_back(make_row(MODE_POP_FRONT, 32'h0, 1'b1, empty_res));
        // alternate ends until full, wrapping the front index below zero
        for (int i = 0; i < DEPTH; i++)
            directed_rows.push_back(make_row((i % 2 == 0) ? MODE_PUSH_FRONT : MODE_PUSH_REAR,
                32'h100 + i, (i == DEPTH - 1),
                make_result(ST_DONE, 1'b0, 1'b1, DEPTH, 32'h10e, 32'h10f)));
        directed_rows.push_back(make_row(MODE_PUSH_FRONT, 32'hdead_beef, 1'b1, full_res));
        directed_rows.push_back(make_row(MODE_PUSH_REAR, 32'h0bad_f00d, 1'b1, full_res));
        directed_rows.push_back(make_row(MODE_POP_REAR, 32'h0, 1'b0, none));
        directed_rows.push_back(make_row(MODE_POP_FRONT, 32'h0, 1'b0, none));

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].value,
                         directed_rows[i].typed, directed_rows[i].want);

        // random part: swing between filling and draining so both ends are hit often
        bias       = 50;
        phase_left = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 2))
                    0: bias = 85;
                    1: bias = 15;
                    default: bias = 50;
                endcase
                phase_left = $urandom_range(20, 60);
                no_idle    = ($urandom_range(0, 5) == 0);
            end
            phase_left--;
            want_push = ($urandom_range(0, 99) < bias);
            if (want_push)
                op = $urandom_range(0, 1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
            else
                op = $urandom_range(0, 1) ? MODE_POP_REAR : MODE_POP_FRONT;
            send_request(op, pick_value(), 1'b0, none);
        end
        s_tvalid = 1'b0;
        no_idle  = 1'b0;

        while (awaiting_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (awaiting_results.size() != 0)
            error_count++;
        $display("%0d requests, %0d results checked, %0d mismatches",
                 reqs_sent, results_seen, error_count);
        $display("full seen %0d times, %0d push rejects, %0d pop rejects",
                 times_full, full_rejects, empty_rejects);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
